// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the slot table with decay
// Types, register indexes and reset values used by more than one file.
// ----------------------------------------------------------------------------
package sst_pkg;

  // default table geometry and level width
  localparam int DAYS_DEF       = 7;
  localparam int SLOTS_DEF      = 24;
  localparam int LEVEL_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_AMOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MUL   = 2'd2;

  localparam logic [CFG_W-1:0] STEP_AMOUNT_RST = 16'd410;
  localparam logic [CFG_W-1:0] MAX_LEVEL_RST   = 16'd40960;
  localparam logic [CFG_W-1:0] DECAY_MUL_RST   = 16'd64225;

  // fraction bits of the decay factor
  localparam int DECAY_FRAC = 16;

  // item kinds
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] step_amount;
    logic [CFG_W-1:0] max_level;
    logic [CFG_W-1:0] decay_mul;
  } cfg_regs_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

// ===== rtl/saturating_slot_table_with_decay.sv =====
// ----------------------------------------------------------------------------
// saturating_slot_table_with_decay: weekly activity table with cap and decay
// DAYS x SLOTS_PER_DAY Q4.12 levels held in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                               Handshake
// input     in         start, in_action, in_day, in_hour   start && !busy
// result    out        out_valid, out_level, out_capped    out_valid strobe
// config    in         cfg_we, cfg_index, cfg_wdata        cfg_we
//
// A read, an out-of-range item or an uncapped record passes through accept,
// then memory lookup and write-back; the word appears the cycle after.
// A capped record goes on to a decay walk, which reads the other slots of the
// day, one per cycle, through the single memory read port, with a two-stage
// multiply and write-back behind it.
// After reset the memory is cleared one entry per cycle with busy high.
// The receiver cannot stall; out_valid lasts one cycle.
// ----------------------------------------------------------------------------
module saturating_slot_table_with_decay #(
  parameter int DAYS          = sst_pkg::DAYS_DEF,
  parameter int SLOTS_PER_DAY = sst_pkg::SLOTS_DEF,
  parameter int LEVEL_BITS    = sst_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [2:0]                    in_day,
  input  logic [4:0]                    in_hour,
  output logic                          out_valid,
  output logic [15:0]                   out_level,
  output logic                          out_capped,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = DAYS * SLOTS_PER_DAY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sst_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  sst_pkg::mem_ctrl_t  mem_ctrl;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [LEVEL_BITS-1:0] mem_wdata;
  logic [LEVEL_BITS-1:0] mem_rdata;

  // register writes; unknown indexes drop the word
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sst_pkg::CFG_STEP_AMOUNT: cfg_nxt.step_amount = cfg_wdata;
        sst_pkg::CFG_MAX_LEVEL:   cfg_nxt.max_level   = cfg_wdata;
        sst_pkg::CFG_DECAY_MUL:   cfg_nxt.decay_mul   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_amount <= sst_pkg::STEP_AMOUNT_RST;
      cfg_r.max_level   <= sst_pkg::MAX_LEVEL_RST;
      cfg_r.decay_mul   <= sst_pkg::DECAY_MUL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sst_seq #(
    .DAYS          (DAYS),
    .SLOTS_PER_DAY (SLOTS_PER_DAY),
    .LEVEL_BITS    (LEVEL_BITS),
    .ADDR_W        (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_day     (in_day),
    .in_hour    (in_hour),
    .cfg        (cfg_r),
    .mem_ctrl   (mem_ctrl),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_valid),
    .out_level  (out_level),
    .out_capped (out_capped)
  );

  sst_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (LEVEL_BITS)
  ) u_mem (
    .clk   (clk),
    .ctrl  (mem_ctrl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/sst_mem.sv =====
// ----------------------------------------------------------------------------
// sst_mem: slot level store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sst_mem #(
  parameter int DEPTH  = sst_pkg::DAYS_DEF * sst_pkg::SLOTS_DEF,
  parameter int ADDR_W = 8,
  parameter int DATA_W = sst_pkg::LEVEL_BITS_DEF
) (
  input  logic              clk,
  input  sst_pkg::mem_ctrl_t ctrl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sst_seq.sv =====
// ----------------------------------------------------------------------------
// sst_seq: item sequencer for the slot table
// Clears the store after reset, looks up and updates one slot per item and
// walks the other slots of the day through the decay multiplier when the cap fires.
// ----------------------------------------------------------------------------
module sst_seq #(
  parameter int DAYS          = sst_pkg::DAYS_DEF,
  parameter int SLOTS_PER_DAY = sst_pkg::SLOTS_DEF,
  parameter int LEVEL_BITS    = sst_pkg::LEVEL_BITS_DEF,
  parameter int ADDR_W        = (DAYS * SLOTS_PER_DAY > 1) ? $clog2(DAYS * SLOTS_PER_DAY) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [2:0]               in_day,
  input  logic [4:0]               in_hour,
  input  sst_pkg::cfg_regs_t       cfg,
  output sst_pkg::mem_ctrl_t       mem_ctrl,
  output logic [ADDR_W-1:0]        mem_waddr,
  output logic [LEVEL_BITS-1:0]    mem_wdata,
  output logic [ADDR_W-1:0]        mem_raddr,
  input  logic [LEVEL_BITS-1:0]    mem_rdata,
  output logic                     out_valid,
  output logic [15:0]              out_level,
  output logic                     out_capped
);

  localparam int DEPTH  = DAYS * SLOTS_PER_DAY;
  localparam int CNT_W  = $clog2(SLOTS_PER_DAY + 1);
  localparam int CMP_W  = CNT_W + 5;
  localparam int SUM_W  = ((LEVEL_BITS > sst_pkg::CFG_W) ? LEVEL_BITS : sst_pkg::CFG_W) + 1;
  localparam int PROD_W = LEVEL_BITS + sst_pkg::DECAY_FRAC;

  localparam logic [LEVEL_BITS-1:0] LVL_ONES = '1;
  localparam logic [ADDR_W-1:0]     CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]      SLOT_END = CNT_W'(SLOTS_PER_DAY);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  function automatic logic [15:0] lvl16(input logic [LEVEL_BITS-1:0] v);
    logic [LEVEL_BITS+15:0] t;
    t = (LEVEL_BITS + 16)'(v);
    return t[15:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]    rd_h_r, rd_h_nxt;
  logic                v1_r, v1_nxt;
  logic                v2_r, v2_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_level_r, out_level_nxt;
  logic                out_capped_r, out_capped_nxt;

  logic                act_r;
  logic                in_rng_r;
  logic [4:0]          hour_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   base_r;
  logic [ADDR_W-1:0]   a1_r;
  logic [ADDR_W-1:0]   a2_r;
  logic [PROD_W-1:0]   prod_r;
  logic [LEVEL_BITS-1:0] cap_lvl_r;

  logic                in_rng;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   in_base;
  logic [ADDR_W-1:0]   walk_addr;
  logic                walk_more;
  logic                walk_other;
  logic [SUM_W-1:0]    sum;
  logic                cap_hit;
  logic [LEVEL_BITS-1:0] sum_val;
  logic [LEVEL_BITS-1:0] cap_val;
  logic                accept;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);

  assign in_rng  = (32'(in_day) < DAYS) && (32'(in_hour) < SLOTS_PER_DAY);
  assign in_base = ADDR_W'(32'(in_day) * SLOTS_PER_DAY);
  assign in_addr = ADDR_W'(32'(in_day) * SLOTS_PER_DAY + 32'(in_hour));

  assign walk_addr  = base_r + ADDR_W'(rd_h_r);
  assign walk_more  = (rd_h_r < SLOT_END);
  assign walk_other = (CMP_W'(rd_h_r) != CMP_W'(hour_r));

  // update path: add, compare against the cap, saturate to the level width
  assign sum     = SUM_W'(mem_rdata) + SUM_W'(cfg.step_amount);
  assign cap_hit = (sum > SUM_W'(cfg.max_level));
  assign sum_val = (sum > SUM_W'(LVL_ONES)) ? LVL_ONES : LEVEL_BITS'(sum);
  assign cap_val = (SUM_W'(cfg.max_level) > SUM_W'(LVL_ONES)) ? LVL_ONES
                                                              : LEVEL_BITS'(cfg.max_level);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    rd_h_nxt       = rd_h_r;
    v1_nxt         = 1'b0;
    v2_nxt         = v1_r;
    out_valid_nxt  = 1'b0;
    out_level_nxt  = out_level_r;
    out_capped_nxt = out_capped_r;
    mem_ctrl       = '0;
    mem_raddr      = in_addr;
    mem_waddr      = addr_r;
    mem_wdata      = sum_val;

    case (state_r)
      S_CLEAR: begin
        mem_ctrl.wr_en = 1'b1;
        mem_waddr      = clr_cnt_r;
        mem_wdata      = '0;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          mem_ctrl.rd_en = in_rng;
          state_nxt      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!in_rng_r) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = '0;
          out_capped_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end else if (act_r == sst_pkg::ACT_READ) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = lvl16(mem_rdata);
          out_capped_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end else if (cap_hit) begin
          mem_ctrl.wr_en = 1'b1;
          mem_wdata      = cap_val;
          rd_h_nxt       = '0;
          state_nxt      = S_WALK;
        end else begin
          mem_ctrl.wr_en = 1'b1;
          out_valid_nxt  = 1'b1;
          out_level_nxt  = lvl16(sum_val);
          out_capped_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_WALK: begin
        // read, multiply, write back: three slots in flight at once
        mem_raddr = walk_addr;
        if (walk_more) begin
          mem_ctrl.rd_en = walk_other;
          v1_nxt         = walk_other;
          rd_h_nxt       = rd_h_r + CNT_W'(1);
        end
        if (v2_r) begin
          mem_ctrl.wr_en = 1'b1;
          mem_waddr      = a2_r;
          mem_wdata      = prod_r[PROD_W-1 -: LEVEL_BITS];
        end
        if (!walk_more && !v1_r && !v2_r) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = lvl16(cap_lvl_r);
          out_capped_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      rd_h_r       <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      out_level_r  <= '0;
      out_capped_r <= 1'b0;
      in_rng_r     <= 1'b0;
      act_r        <= sst_pkg::ACT_READ;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      rd_h_r       <= rd_h_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      out_valid_r  <= out_valid_nxt;
      out_level_r  <= out_level_nxt;
      out_capped_r <= out_capped_nxt;
      if (accept) begin
        in_rng_r <= in_rng;
        act_r    <= in_action;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hour_r <= in_hour;
      addr_r <= in_addr;
      base_r <= in_base;
    end
    if (state_r == S_LOOK) begin
      cap_lvl_r <= cap_val;
    end
    a1_r   <= walk_addr;
    a2_r   <= a1_r;
    prod_r <= PROD_W'(mem_rdata) * PROD_W'(cfg.decay_mul);
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_capped = out_capped_r;

endmodule

// ===== rtl/sst_chk.sv =====
// ----------------------------------------------------------------------------
// sst_chk: port-level checks for the slot table
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module sst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_level,
  input logic        out_capped
);

  // an accepted word always keeps the block occupied for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result never appears while an item is still in work
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // at most one result per item: results are never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // no result in the cycle straight after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result too early after accept");

  // the capped flag only moves together with a result strobe
  a_capped_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_capped != $past(out_capped)) |-> out_valid)
    else $error("capped flag changed outside a result");

endmodule

bind saturating_slot_table_with_decay sst_chk u_sst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_level  (out_level),
  .out_capped (out_capped)
);
